@@ design/gf2_reduced_basis_unit_defines.svh @@
// Assertion macros shared by the GF(2) reduced basis unit modules.
`ifndef GF2_REDUCED_BASIS_UNIT_DEFINES_SVH
`define GF2_REDUCED_BASIS_UNIT_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define GRBU_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("grbu assertion failed");

// Clocked check that also holds during reset.
`define GRBU_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("grbu assertion failed");

`endif

@@ design/grbu_pkg.sv @@
// Types and constants shared by the GF(2) reduced basis unit modules.
package grbu_pkg;

  localparam int unsigned OPND_W = 64;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned PIV_W  = 6;
  localparam int unsigned RANK_W = 7;
  localparam int unsigned COEF_W = 64;
  localparam int unsigned RES_W  = 80;

  localparam logic [RANK_W-1:0] RANK_CAP_RST = 7'd64;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT   = 2'd0,
    FUNC_CONTAINS = 2'd1,
    FUNC_COORDS   = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_e;

  typedef struct packed {
    logic load;
    logic red;
    logic lod;
    logic elim;
    logic cstep;
    logic finish;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  indep;
    logic  cap_ok;
    logic  cdone;
  } sts_t;

endpackage

@@ design/grbu_dp.sv @@
// Datapath: basis rows, reduction tree, pivot search, elimination and coefficient compaction.
`include "gf2_reduced_basis_unit_defines.svh"

module grbu_dp #(
  parameter int unsigned VECTOR_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  grbu_pkg::cmd_t                   cmd_i,
  output grbu_pkg::sts_t                   sts_o,
  input  logic [grbu_pkg::OPND_W-1:0]      opnd_i,
  input  logic [grbu_pkg::FUNC_W-1:0]      func_i,
  input  logic                             cfg_we_i,
  input  logic [grbu_pkg::RANK_W-1:0]      cfg_wdata_i,
  output logic [grbu_pkg::RES_W-1:0]       res_o
);

  localparam int unsigned VB = VECTOR_BITS;
  localparam int unsigned NG = (VB + 7) / 8;
  localparam int unsigned PW = NG * 8;
  localparam int unsigned LW = $clog2(VB);
  localparam int unsigned SW = (NG > 1) ? $clog2(NG) : 1;

  logic [VB-1:0]                   rows_q [VB];
  logic [VB-1:0]                   vld_q;
  logic [VB-1:0]                   v_q;
  logic [VB-1:0]                   r_q, r_d;
  logic [VB-1:0]                   part_q [NG];
  logic [VB-1:0]                   part_d [NG];
  logic [VB-1:0]                   opnd;
  logic [VB-1:0]                   hit;
  logic [LW-1:0]                   piv_q, piv_d;
  logic                            added_q;
  grbu_pkg::func_e                 func_q;
  logic [grbu_pkg::RANK_W-1:0]     rank_q, cap_q;
  logic [PW-1:0]                   cv_q, cm_q;
  logic [grbu_pkg::COEF_W-1:0]     coef_q;
  logic [grbu_pkg::RANK_W-1:0]     cnt_q;
  logic [SW-1:0]                   step_q;
  logic [grbu_pkg::RES_W-1:0]      res_q, res_d;
  logic [7:0]                      cmask, cbits, cb;
  logic [3:0]                      cj;
  logic                            indep;

  assign opnd  = opnd_i[VB-1:0];
  assign indep = |r_q;

  // first reduction stage: one partial XOR per group of eight rows
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      part_d[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if (g * 8 + j < VB) begin
          if (vld_q[g*8+j] && opnd[g*8+j]) begin
            part_d[g] = part_d[g] ^ rows_q[g*8+j];
          end
        end
      end
    end
  end

  always_comb begin
    r_d = v_q;
    for (int g = 0; g < NG; g++) begin
      r_d = r_d ^ part_q[g];
    end
  end

  always_comb begin
    piv_d = '0;
    for (int i = 0; i < VB; i++) begin
      if (r_q[i]) begin
        piv_d = LW'(i);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < VB; k++) begin
      hit[k] = vld_q[k] & rows_q[k][piv_q];
    end
  end

  // pack the coefficient bits of one byte of pivot slots
  always_comb begin
    cmask = cm_q[7:0];
    cbits = cv_q[7:0] & cmask;
    cb    = '0;
    cj    = '0;
    for (int i = 0; i < 8; i++) begin
      if (cmask[i]) begin
        if (cbits[i]) begin
          cb[cj[2:0]] = 1'b1;
        end
        cj = cj + 4'd1;
      end
    end
  end

  always_comb begin
    logic                         success, inspan;
    logic [grbu_pkg::PIV_W-1:0]   pivo;
    logic [grbu_pkg::COEF_W-1:0]  coefo;
    logic [grbu_pkg::RANK_W-1:0]  ranko;
    success = (func_q == grbu_pkg::FUNC_INSERT) && (!indep || added_q);
    inspan  = (func_q != grbu_pkg::FUNC_CLEAR) && !indep;
    pivo    = added_q ? grbu_pkg::PIV_W'(piv_q) : '0;
    coefo   = (func_q == grbu_pkg::FUNC_COORDS && !indep) ? coef_q : '0;
    ranko   = (func_q == grbu_pkg::FUNC_CLEAR) ? '0 : rank_q;
    res_d   = {ranko, coefo, pivo, added_q, inspan, success};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.elim) begin
      for (int k = 0; k < VB; k++) begin
        if (LW'(k) == piv_q) begin
          rows_q[k] <= r_q;
        end else if (hit[k]) begin
          rows_q[k] <= rows_q[k] ^ r_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rank_q  <= '0;
      cap_q   <= grbu_pkg::RANK_CAP_RST;
      added_q <= 1'b0;
      step_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        added_q <= 1'b0;
        step_q  <= '0;
      end
      if (cmd_i.cstep) begin
        step_q <= step_q + SW'(1);
      end
      if (cmd_i.elim) begin
        vld_q[piv_q] <= 1'b1;
        rank_q       <= rank_q + 7'd1;
        added_q      <= 1'b1;
      end
      if (cmd_i.finish && func_q == grbu_pkg::FUNC_CLEAR) begin
        vld_q  <= '0;
        rank_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q    <= opnd;
      func_q <= grbu_pkg::func_e'(func_i);
      part_q <= part_d;
      cv_q   <= PW'(opnd);
      cm_q   <= PW'(vld_q);
      coef_q <= '0;
      cnt_q  <= '0;
    end
    if (cmd_i.red) begin
      r_q <= r_d;
    end
    if (cmd_i.lod) begin
      piv_q <= piv_d;
    end
    if (cmd_i.cstep) begin
      coef_q <= coef_q | (grbu_pkg::COEF_W'(cb) << cnt_q);
      cnt_q  <= cnt_q + grbu_pkg::RANK_W'(cj);
      cv_q   <= cv_q >> 8;
      cm_q   <= cm_q >> 8;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign sts_o.func   = func_q;
  assign sts_o.indep  = indep;
  assign sts_o.cap_ok = rank_q < cap_q;
  assign sts_o.cdone  = step_q == SW'(NG - 1);
  assign res_o        = res_q;

  `GRBU_ASSERT(a_rank_matches_rows, clk_i, rst_ni, $countones(vld_q) == int'(rank_q))
  `GRBU_ASSERT(a_new_row_valid, clk_i, rst_ni, cmd_i.elim |=> vld_q[$past(piv_q)])
  `GRBU_ASSERT(a_rank_bound, clk_i, rst_ni, rank_q <= 7'(VB))

endmodule

@@ design/grbu_ctrl.sv @@
// Controller: operation sequencer and output transfer handshake.
`include "gf2_reduced_basis_unit_defines.svh"

module grbu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output grbu_pkg::cmd_t  cmd_o,
  input  grbu_pkg::sts_t  sts_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_LOD  = 3'd2;
  localparam logic [2:0] S_ELIM = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       mv_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RED;
        end
      end
      S_RED: begin
        cmd_o.red = 1'b1;
        case (sts_i.func)
          grbu_pkg::FUNC_INSERT: state_d = S_LOD;
          grbu_pkg::FUNC_COORDS: state_d = S_CMP;
          default:               state_d = S_FIN;
        endcase
      end
      S_LOD: begin
        cmd_o.lod = 1'b1;
        if (sts_i.indep && sts_i.cap_ok) begin
          state_d = S_ELIM;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ELIM: begin
        cmd_o.elim = 1'b1;
        state_d    = S_FIN;
      end
      S_CMP: begin
        cmd_o.cstep = 1'b1;
        if (sts_i.cdone) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!mv_q || m_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.finish) begin
        mv_q <= 1'b1;
      end else if (m_ready_i) begin
        mv_q <= 1'b0;
      end
    end
  end

  assign s_ready_o = state_q == S_IDLE;
  assign m_valid_o = mv_q;

  `GRBU_ASSERT(a_fin_holds_on_stall, clk_i, rst_ni, (state_q == S_FIN && mv_q && !m_ready_i) |=> (state_q == S_FIN))
  `GRBU_ASSERT(a_elim_after_lod, clk_i, rst_ni, (state_q == S_ELIM) |-> ($past(state_q) == S_LOD))
  `GRBU_ASSERT(a_mvalid_hold, clk_i, rst_ni, (m_valid_o && !m_ready_i) |=> m_valid_o)

endmodule

@@ design/gf2_reduced_basis_unit.sv @@
// Top level of the GF(2) reduced basis unit.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid/s_axis_tready    tdata operand, tuser func
//   m_axis    out  m_axis_tvalid/m_axis_tready    tdata result fields
//   cfg       in   cfg_we_i                       cfg_wdata_i rank cap
//
// An operation runs through the two-stage registered reduction tree, then for insert the
// pivot search and, when a row is added, the elimination step, or for coordinates the
// byte-serial coefficient packer.
// Reset clears the row valid bits and rank at once; no clearing pass.
// An input transfer is taken while a finished result waits; the next result is
// held in its last step until m_axis_tready frees the output register.
module gf2_reduced_basis_unit #(
  parameter int unsigned VECTOR_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] operand_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [0] success, [1] in_span, [2] added_row,
                                      // [8:3] new_pivot, [72:9] coefficients,
                                      // [79:73] rank_now
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i
);

  grbu_pkg::cmd_t cmd;
  grbu_pkg::sts_t sts;

  grbu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  grbu_dp #(
    .VECTOR_BITS (VECTOR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .opnd_i      (s_axis_tdata),
    .func_i      (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (m_axis_tdata)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Testbench for gf2_reduced_basis_unit: directed table, then random phases under several caps.
module tb;

  localparam int IDLE_LIMIT  = 1000;
  localparam int ERR_SHOW    = 10;
  localparam int DIR_N       = 30;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 256;

  typedef struct packed {
    logic [grbu_pkg::RANK_W-1:0] rank_now;
    logic [grbu_pkg::COEF_W-1:0] coefficients;
    logic [grbu_pkg::PIV_W-1:0]  new_pivot;
    logic                        added_row;
    logic                        in_span;
    logic                        success;
  } result_t;

  typedef struct packed {
    logic                        is_cfg;
    grbu_pkg::func_e             func;
    logic [grbu_pkg::OPND_W-1:0] operand;
    logic                        typed;
    logic [grbu_pkg::RES_W-1:0]  want;
  } stim_row_t;

  // cfg rows carry the new rank cap in operand
  localparam stim_row_t DIR_TAB [DIR_N] = '{
    '{1'b0, grbu_pkg::FUNC_CONTAINS, 64'h0, 1'b1, 80'h2},
    '{1'b0, grbu_pkg::FUNC_COORDS,   64'h0, 1'b1, 80'h2},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'h0, 1'b1, 80'h3},
    '{1'b0, grbu_pkg::FUNC_CONTAINS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 80'h0},
    '{1'b0, grbu_pkg::FUNC_COORDS,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 80'h0},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'h1, 1'b1, 80'h0200_0000_0000_0000_0005},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'h8000_0000_0000_0000, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'h8000_0000_0000_0001, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_COORDS,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_COORDS,   64'h8000_0000_0000_0001, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_CONTAINS, 64'h4000_0000_0000_0000, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'h5555_5555_5555_5555, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_COORDS,   64'h0123_4567_89AB_CDEF, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_CLEAR,    64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 80'h0},
    '{1'b0, grbu_pkg::FUNC_CONTAINS, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 80'h0},
    '{1'b1, grbu_pkg::FUNC_INSERT,   64'd0, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'h1, 1'b1, 80'h0},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'h0, 1'b1, 80'h3},
    '{1'b1, grbu_pkg::FUNC_INSERT,   64'd2, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'h0000_0000_0000_00F0, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'h0000_0000_0000_0F00, 1'b0, 80'h0},
    '{1'b1, grbu_pkg::FUNC_INSERT,   64'd1, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'hF000_0000_0000_0000, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'h0000_0000_0000_0FF0, 1'b0, 80'h0},
    '{1'b1, grbu_pkg::FUNC_INSERT,   64'd127, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_INSERT,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 80'h0},
    '{1'b0, grbu_pkg::FUNC_CLEAR,    64'h0, 1'b1, 80'h0},
    '{1'b1, grbu_pkg::FUNC_INSERT,   64'd64, 1'b0, 80'h0}
  };

  localparam logic [grbu_pkg::RANK_W-1:0] PHASE_CAP [PHASES] = '{
    7'd127, 7'd64, 7'd5, 7'd0, 7'd40, 7'd1, 7'd64
  };

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [grbu_pkg::OPND_W-1:0] s_axis_tdata  = '0;
  logic [grbu_pkg::FUNC_W-1:0] s_axis_tuser  = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [grbu_pkg::RES_W-1:0]  m_axis_tdata;
  logic                        cfg_we_i      = 1'b0;
  logic [grbu_pkg::RANK_W-1:0] cfg_wdata_i   = '0;

  logic [grbu_pkg::OPND_W-1:0] basis_row [grbu_pkg::OPND_W];
  logic [grbu_pkg::RANK_W-1:0] basis_rank;
  logic [grbu_pkg::RANK_W-1:0] rank_cap;
  result_t                     pending_results [$];
  int                          err_count   = 0;
  int                          idle_cycles = 0;
  bit                          no_idle     = 1'b0;

  gf2_reduced_basis_unit #(
    .VECTOR_BITS(64)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic logic [grbu_pkg::OPND_W-1:0] reduce_vec(
    logic [grbu_pkg::OPND_W-1:0] v);
    for (int p = grbu_pkg::OPND_W - 1; p >= 0; p--) begin
      if (v[p] && basis_row[p] != '0) v ^= basis_row[p];
    end
    return v;
  endfunction

  function automatic result_t apply_basis_op(grbu_pkg::func_e f,
                                             logic [grbu_pkg::OPND_W-1:0] v);
    result_t                     res;
    logic [grbu_pkg::OPND_W-1:0] rem;
    int                          piv;
    int                          k;
    res = '0;
    case (f)
      grbu_pkg::FUNC_INSERT: begin
        rem = reduce_vec(v);
        if (rem == '0) begin
          res.in_span = 1'b1;
          res.success = 1'b1;
        end else if (basis_rank < rank_cap) begin
          piv = 0;
          for (int b = 0; b < grbu_pkg::OPND_W; b++) begin
            if (rem[b]) piv = b;
          end
          for (int r = 0; r < grbu_pkg::OPND_W; r++) begin
            if (basis_row[r][piv]) basis_row[r] ^= rem;
          end
          basis_row[piv] = rem;
          basis_rank = basis_rank + 1'b1;
          res.success = 1'b1;
          res.added_row = 1'b1;
          res.new_pivot = grbu_pkg::PIV_W'(piv);
        end
      end
      grbu_pkg::FUNC_CONTAINS: begin
        res.in_span = (reduce_vec(v) == '0);
      end
      grbu_pkg::FUNC_COORDS: begin
        res.in_span = (reduce_vec(v) == '0);
        if (res.in_span) begin
          k = 0;
          for (int p = 0; p < grbu_pkg::OPND_W; p++) begin
            if (basis_row[p] != '0) begin
              if (v[p]) res.coefficients[k] = 1'b1;
              k++;
            end
          end
        end
      end
      default: begin
        for (int r = 0; r < grbu_pkg::OPND_W; r++) basis_row[r] = '0;
        basis_rank = '0;
      end
    endcase
    res.rank_now = basis_rank;
    return res;
  endfunction

  // three in ten operands are span combinations so coordinates and dependent inserts are common
  function automatic logic [grbu_pkg::OPND_W-1:0] make_operand();
    logic [grbu_pkg::OPND_W-1:0] v;
    int                          idx;
    v = '0;
    idx = $urandom_range(0, grbu_pkg::OPND_W - 1);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        for (int r = 0; r < grbu_pkg::OPND_W; r++) begin
          if ($urandom_range(0, 1) == 1) v ^= basis_row[r];
        end
        if ($urandom_range(0, 2) == 0) v[idx] = ~v[idx];
      end
      3, 4:    v = {$urandom, $urandom};
      5:       v[idx] = 1'b1;
      6:       v = grbu_pkg::OPND_W'($urandom_range(0, 255)) << $urandom_range(0, 56);
      7:       v = ($urandom_range(0, 1) == 1) ? '1 : '0;
      default: v = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_error(string msg);
    if (err_count < ERR_SHOW) $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endfunction

  task automatic send_op(grbu_pkg::func_e f, logic [grbu_pkg::OPND_W-1:0] v,
                         logic typed, logic [grbu_pkg::RES_W-1:0] want);
    int      gap;
    result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = apply_basis_op(f, v);
    if (typed) pred = result_t'(want);
    pending_results = {pending_results, pred};
  endtask

  task automatic write_cap(logic [grbu_pkg::RANK_W-1:0] cap);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    rank_cap = cap;
  endtask

  initial begin
    int              r;
    grbu_pkg::func_e f;
    for (int i = 0; i < grbu_pkg::OPND_W; i++) basis_row[i] = '0;
    basis_rank = '0;
    rank_cap   = grbu_pkg::RANK_CAP_RST;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].is_cfg) begin
        write_cap(DIR_TAB[i].operand[grbu_pkg::RANK_W-1:0]);
      end else begin
        send_op(DIR_TAB[i].func, DIR_TAB[i].operand, DIR_TAB[i].typed, DIR_TAB[i].want);
      end
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      write_cap(PHASE_CAP[ph]);
      no_idle = (ph == 2 || ph == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        // no clears in the first phase so the basis fills to full rank
        if (ph != 0 && r < 3) f = grbu_pkg::FUNC_CLEAR;
        else if (r < 40)      f = grbu_pkg::FUNC_INSERT;
        else if (r < 60)      f = grbu_pkg::FUNC_CONTAINS;
        else                  f = grbu_pkg::FUNC_COORDS;
        send_op(f, make_operand(), 1'b0, '0);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("PASS gf2_reduced_basis_unit");
    end else begin
      $display("FAIL gf2_reduced_basis_unit");
    end
    $finish;
  end

  initial begin
    int run;
    int stall;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(1, 12);
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      repeat (run - 1) @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_results.size() == 0) begin
          note_error($sformatf("result %h with nothing pending", m_axis_tdata));
        end else begin
          want = pending_results.pop_front();
          if (got.success !== want.success || got.in_span !== want.in_span ||
              got.added_row !== want.added_row || got.new_pivot !== want.new_pivot ||
              got.coefficients !== want.coefficients || got.rank_now !== want.rank_now) begin
            note_error($sformatf(
              "want succ=%b span=%b add=%b piv=%0d coef=%h rank=%0d, got %b %b %b %0d %h %0d",
              want.success, want.in_span, want.added_row, want.new_pivot,
              want.coefficients, want.rank_now, got.success, got.in_span,
              got.added_row, got.new_pivot, got.coefficients, got.rank_now));
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL gf2_reduced_basis_unit");
        $finish;
      end
    end
  end

endmodule

@@ sim.f @@
+incdir+design
design/grbu_pkg.sv
design/grbu_dp.sv
design/grbu_ctrl.sv
design/gf2_reduced_basis_unit.sv
dv/tb.sv
